// ===== sv/spq_pkg.sv =====
package spq_pkg;

	// Number of cells in the chain, one held entry per cell.
	localparam int unsigned QUEUE_DEPTH = 16;

	// Entry count reaches QUEUE_DEPTH, so it needs one more code than the depth.
	localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OCC_W   = 5;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [OCC_W-1:0]   occ_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// Action codes on the request channel.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Status codes on the response channel.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic   ins;
		logic   rem;
		value_t value;
	} cell_cmd_t;

endpackage

// ===== sv/spq_if.sv =====
// Request channel: one beat per insert or remove.
interface spq_req_if;
	logic                valid;
	logic                ready;
	logic                action;
	spq_pkg::value_t     value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

// Response channel: one beat per request.
interface spq_rsp_if;
	logic                valid;
	logic                ready;
	spq_pkg::value_t     removed_value;
	logic [1:0]          status;
	spq_pkg::occ_t       occupancy;

	modport source (output valid, output removed_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input removed_value, input status, input occupancy,
		output ready);
endinterface

// ===== sv/spq_cell.sv =====
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_cmd_t  cmd,
	input  logic                occupied,
	input  logic                left_take,
	input  spq_pkg::value_t     left_entry,
	input  spq_pkg::value_t     right_entry,
	output logic                take,
	output spq_pkg::value_t     entry
);

	spq_pkg::value_t entry_q;

	// This cell moves on an insert when it is free or holds a larger value.
	assign take  = !occupied || (entry_q > cmd.value);
	assign entry = entry_q;

	// Insert shifts right from the insertion point; remove shifts everything left.
	always_ff @(posedge clk) begin
		if (cmd.ins && take) begin
			entry_q <= left_take ? left_entry : cmd.value;
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	spq_req_if.sink             req,
	spq_rsp_if.source           rsp,
	input  spq_pkg::value_t     head_entry,
	output spq_pkg::cell_cmd_t  cmd,
	output spq_pkg::count_t     count
);

	spq_pkg::count_t count_q;
	spq_pkg::count_t count_d;
	logic            rsp_valid_q;
	spq_pkg::value_t removed_q;
	logic [1:0]      status_q;
	spq_pkg::occ_t   occ_q;
	logic            accept;
	logic            full;
	logic            empty;
	logic [1:0]      status_d;
	spq_pkg::value_t removed_d;

	// A new request is taken whenever the response register is free or draining.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == spq_pkg::count_t'(spq_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign cmd.ins   = accept && (req.action == spq_pkg::ACT_INSERT) && !full;
	assign cmd.rem   = accept && (req.action == spq_pkg::ACT_REMOVE) && !empty;
	assign cmd.value = req.value;

	// Result of the current request, from the count and the head cell.
	always_comb begin
		count_d   = count_q;
		status_d  = spq_pkg::ST_DONE;
		removed_d = '0;
		if (req.action == spq_pkg::ACT_REMOVE) begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				removed_d = head_entry;
				count_d   = count_q - spq_pkg::count_t'(1);
			end
		end else begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				count_d = count_q + spq_pkg::count_t'(1);
			end
		end
	end

	// Entry count and the response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, loaded with each accepted request.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= removed_d;
			status_q  <= status_d;
			occ_q     <= spq_pkg::occ_t'(count_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.occupancy     = occ_q;
	assign count             = count_q;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue of up to QUEUE_DEPTH signed 32-bit values, kept ascending in a chain of
// cells, one entry per cell. An insert places the value after every held entry less than or
// equal to it, so equal values leave in arrival order; a remove returns the smallest entry.
// Every request gives exactly one response beat with the removed value (zero unless a remove
// succeeded), a status (done, refused because full, refused because empty) and the occupancy
// after the request. Every cell compares its entry with the new value and shifts toward its
// neighbor in the same cycle, and the response is registered and appears in the cycle after
// acceptance. A new request is accepted in every cycle while the response channel takes
// beats; while a response beat is stalled, no further request is accepted.
module sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	spq_req_if.sink     req,
	spq_rsp_if.source   rsp
);

	localparam int unsigned DEPTH = spq_pkg::QUEUE_DEPTH;

	spq_pkg::cell_cmd_t cmd;
	spq_pkg::count_t    count;
	logic               take  [DEPTH];
	spq_pkg::value_t    entry [DEPTH];

	// Request handling, entry count and response register.
	spq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.head_entry (entry[0]),
		.cmd        (cmd),
		.count      (count)
	);

	// The cell chain; the first cell has no left neighbor, the last no right one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic            occupied;
		logic            left_take;
		spq_pkg::value_t left_entry;
		spq_pkg::value_t right_entry;

		assign occupied = (count > spq_pkg::count_t'(i));

		if (i == 0) begin : g_first
			assign left_take  = 1'b0;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_take  = take[i-1];
			assign left_entry = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occupied),
			.left_take   (left_take),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.take        (take[i]),
			.entry       (entry[i])
		);
	end

endmodule

// ===== sv/spq_checker.sv =====
module spq_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  spq_pkg::value_t     rsp_removed_value,
	input  logic [1:0]          rsp_status,
	input  spq_pkg::occ_t       rsp_occupancy
);

	// The occupancy never goes past the queue depth.
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_occupancy <= spq_pkg::occ_t'(spq_pkg::QUEUE_DEPTH)))
		else $error("occupancy above queue depth");

	// A refused insert is only reported when the queue is full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == spq_pkg::ST_FULL) |->
		(rsp_occupancy == spq_pkg::occ_t'(spq_pkg::QUEUE_DEPTH) && rsp_removed_value == '0))
		else $error("full status with wrong occupancy or value");

	// A refused remove is only reported when the queue is empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == spq_pkg::ST_EMPTY) |->
		(rsp_occupancy == '0 && rsp_removed_value == '0))
		else $error("empty status with wrong occupancy or value");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == spq_pkg::ST_DONE || rsp_status == spq_pkg::ST_FULL ||
			rsp_status == spq_pkg::ST_EMPTY))
		else $error("undefined status code");

	// A stalled response beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_removed_value) &&
			$stable(rsp_status) && $stable(rsp_occupancy)))
		else $error("response beat changed while stalled");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_removed_value (rsp.removed_value),
	.rsp_status        (rsp.status),
	.rsp_occupancy     (rsp.occupancy)
);
